FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/core/ldc_pkg.sv
// ----------------------------------------------------------------------------
// ldc_pkg
// Shared constants, state type and controller/datapath bundles of the
// CR/LF line deframer.
// ----------------------------------------------------------------------------
package ldc_pkg;

   localparam int BYTE_W       = 8;
   localparam int LINE_LEN_W   = 6;
   localparam int DEF_MAX_LINE = 64;

   localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SHOW
   } ldc_state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;   // input transaction taken this cycle
      logic start;    // terminator opens a readout
      logic read;     // fetch store entry at read index
      logic advance;  // step read index to the next byte
      logic finish;   // line delivered, clear fill count
   } ldc_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_term;    // incoming byte is CR or LF
      logic swallow;    // LF right after CR
      logic fill_zero;  // no bytes stored
      logic at_last;    // current result is the final one of the line
   } ldc_stat_type;

endpackage

FILE: rtl/core/ldc_if.sv
// ----------------------------------------------------------------------------
// ldc_req_if / ldc_rsp_if
// Valid/ready channels for received bytes and for line output.
// ----------------------------------------------------------------------------
interface ldc_req_if import ldc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface ldc_rsp_if import ldc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [BYTE_W-1:0]     out_byte;
   logic                  last;
   logic                  empty_line;
   logic [LINE_LEN_W-1:0] line_length;

   modport source (output valid, output out_byte, output last, output empty_line,
                   output line_length, input ready);
   modport sink   (input valid, input out_byte, input last, input empty_line,
                   input line_length, output ready);
endinterface

FILE: rtl/core/ldc_ctrl.sv
// ----------------------------------------------------------------------------
// ldc_ctrl
// Sequencer: takes bytes while idle, then walks the stored line out
// one byte per fetch/present pair.
// ----------------------------------------------------------------------------
module ldc_ctrl import ldc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  ldc_stat_type stat,
   output ldc_cmd_type  cmd
);

   ldc_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && stat.is_term && !stat.swallow) begin
               state_in = stat.fill_zero ? ST_SHOW : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_ready) begin
               state_in = stat.at_last ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            cmd.start  = req_valid && stat.is_term && !stat.swallow;
         end
         ST_READ: begin
            cmd.read = 1'b1;
         end
         ST_SHOW: begin
            rsp_valid   = 1'b1;
            cmd.advance = rsp_ready && !stat.at_last;
            cmd.finish  = rsp_ready && stat.at_last;
         end
         default: ;
      endcase
   end

endmodule

FILE: rtl/core/ldc_dp.sv
// ----------------------------------------------------------------------------
// ldc_dp
// Line store, fill count, CR history, read index and result register.
// ----------------------------------------------------------------------------
module ldc_dp import ldc_pkg::*; #(
   parameter int MAX_LINE = DEF_MAX_LINE
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ldc_cmd_type           cmd,
   input  logic [BYTE_W-1:0]     in_byte,
   output ldc_stat_type          stat,
   output logic [BYTE_W-1:0]     out_byte,
   output logic                  last,
   output logic                  empty_line,
   output logic [LINE_LEN_W-1:0] line_length
);

   localparam int STORE_DEPTH = MAX_LINE - 1;
   localparam int CNT_W       = $clog2(MAX_LINE);
   localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STORE_DEPTH);

   logic [BYTE_W-1:0] mem [STORE_DEPTH];

   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              prev_cr_ff, prev_cr_in;
   logic              empty_ff, empty_in;
   logic [BYTE_W-1:0] rd_data_ff;

   logic is_cr, is_lf, store_en;

   // classify incoming byte
   assign is_cr    = (in_byte == CH_CR);
   assign is_lf    = (in_byte == CH_LF);
   assign store_en = cmd.accept && !(is_cr || is_lf) && (fill_ff < FULL_CNT);

   assign stat.is_term   = is_cr || is_lf;
   assign stat.swallow   = prev_cr_ff && is_lf;
   assign stat.fill_zero = (fill_ff == '0);
   assign stat.at_last   = empty_ff || ((rd_idx_ff + CNT_W'(1)) == fill_ff);

   // next values of control registers
   always_comb begin
      fill_in    = fill_ff;
      rd_idx_in  = rd_idx_ff;
      prev_cr_in = prev_cr_ff;
      empty_in   = empty_ff;
      if (cmd.accept) begin
         prev_cr_in = is_cr;
      end
      if (store_en) begin
         fill_in = fill_ff + CNT_W'(1);
      end
      if (cmd.start) begin
         rd_idx_in = '0;
         empty_in  = (fill_ff == '0);
      end
      if (cmd.advance) begin
         rd_idx_in = rd_idx_ff + CNT_W'(1);
      end
      if (cmd.finish) begin
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         rd_idx_ff  <= '0;
         prev_cr_ff <= 1'b0;
         empty_ff   <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         rd_idx_ff  <= rd_idx_in;
         prev_cr_ff <= prev_cr_in;
         empty_ff   <= empty_in;
      end
   end

   // line store: write on stored byte, registered read
   always_ff @(posedge clock) begin
      if (store_en) begin
         mem[fill_ff[IDX_W-1:0]] <= in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_data_ff <= mem[rd_idx_ff[IDX_W-1:0]];
      end
   end

   // result fields
   assign out_byte    = empty_ff ? '0 : rd_data_ff;
   assign last        = stat.at_last;
   assign empty_line  = empty_ff;
   assign line_length = LINE_LEN_W'(fill_ff);

endmodule

FILE: rtl/core/line_deframer_crlf_unit.sv
// ----------------------------------------------------------------------------
// line_deframer_crlf_unit
// CR/LF line splitter. Bytes enter on the req channel, one per transaction.
// CR or LF ends a line; an LF directly after a CR is dropped, so CRLF is one
// terminator. Up to MAX_LINE-1 bytes per line are kept, later ones dropped.
// On a terminator the stored bytes leave on the rsp channel in order, the
// final one flagged by last, each carrying line_length. A terminator with
// nothing stored gives one transaction with empty_line and last set.
// Ordinary bytes are taken back to back while idle. A terminator opens a
// readout during which req.ready is low: each line byte, the first one
// included, is fetched from the store in the read state and then presented
// in the show state until rsp.ready; an empty line is presented the cycle
// after its terminator. The registered read of the line store sets this
// pacing.
// A stall on rsp simply holds the presented transaction; nothing is lost.
// Reset (synchronous, active high) clears the fill count, CR history and
// sequencer; the store contents need no clearing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_deframer_crlf_unit import ldc_pkg::*; #(
   parameter int MAX_LINE = DEF_MAX_LINE
) (
   input logic       clock,
   input logic       reset,
   ldc_req_if.sink   req_ch,
   ldc_rsp_if.source rsp_ch
);

   ldc_cmd_type  cmd;
   ldc_stat_type stat;

   // sequencer
   ldc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage and result fields
   ldc_dp #(
      .MAX_LINE (MAX_LINE)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .in_byte     (req_ch.in_byte),
      .stat        (stat),
      .out_byte    (rsp_ch.out_byte),
      .last        (rsp_ch.last),
      .empty_line  (rsp_ch.empty_line),
      .line_length (rsp_ch.line_length)
   );

   // handshake and shape terms for the checks below
   logic req_take, rsp_take, empty_shape_ok;

   assign req_take       = req_ch.valid && req_ch.ready;
   assign rsp_take       = rsp_ch.valid && rsp_ch.ready;
   assign empty_shape_ok = rsp_ch.last && (rsp_ch.line_length == '0) &&
                           (rsp_ch.out_byte == '0);

   // no byte is taken while a line is being presented
   `ASSERT_IMPLIES(a_no_take_during_show, clock, reset, req_take, !rsp_ch.valid)
   // after the final transaction of a line the block is ready again
   `ASSERT_NEXT(a_ready_after_last, clock, reset, rsp_take && rsp_ch.last, req_ch.ready)
   // an empty line is a single transaction of length zero
   `ASSERT_IMPLIES(a_empty_shape, clock, reset, rsp_ch.valid && rsp_ch.empty_line, empty_shape_ok)

endmodule
